// ===== sv/spectrum_bar_gravity_falloff_assert.svh =====
// Assertion macros for the spectrum bar meter.
`ifndef SPECTRUM_BAR_GRAVITY_FALLOFF_ASSERT_SVH
`define SPECTRUM_BAR_GRAVITY_FALLOFF_ASSERT_SVH
`ifndef SYNTH
`define SBGF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`define SBGF_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);
`else
`define SBGF_ASSERT(label, clk, rst, prop, msg)
`define SBGF_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== sv/sbgf_pkg.sv =====
// Shared constants and types of the spectrum bar meter.
`timescale 1ns / 1ps
package sbgf_pkg;

   localparam int BAR_COUNT = 32;
   localparam int SLOT_W    = $clog2(BAR_COUNT);
   localparam int HALF_BARS = BAR_COUNT / 2;
   localparam int LAST_BAR  = BAR_COUNT - 1;

   localparam int IDX_W    = 5;
   localparam int BIN_W    = 24;
   localparam int HEIGHT_W = 25;
   localparam int SPEED_W  = 16;
   localparam int CNT_W    = 6;

   // pair sum, weighted accumulator, quotient and tripled value
   localparam int PAIR_W   = BIN_W + 1;
   localparam int PROD_W   = PAIR_W + 15;
   localparam int ACC_W    = PROD_W + 1;
   localparam int FRAC_W   = 16;
   localparam int QUOT_W   = ACC_W - FRAC_W;
   localparam int VAL_W    = QUOT_W + 2;

   // Q16 weights; the centre weight is a shift by CENTER_SHIFT
   localparam int CENTER_SHIFT = 15;
   localparam logic signed [15:0] W_ONE = 16'sd9830;
   localparam logic signed [15:0] W_TWO = 16'sd6554;

   localparam logic ACT_FRAME = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   typedef struct packed {
      logic             action;
      logic [IDX_W-1:0] bar_index;
   } item_ctl_type;

endpackage

// ===== sv/sbgf_weigh.sv =====
// Two-stage weighted sum of the five bins, truncated and tripled.
`timescale 1ns / 1ps
module sbgf_weigh (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  sbgf_pkg::item_ctl_type                in_ctl,
   input  logic signed [sbgf_pkg::BIN_W-1:0]     bin_center,
   input  logic signed [sbgf_pkg::BIN_W-1:0]     bin_minus_one,
   input  logic signed [sbgf_pkg::BIN_W-1:0]     bin_plus_one,
   input  logic signed [sbgf_pkg::BIN_W-1:0]     bin_minus_two,
   input  logic signed [sbgf_pkg::BIN_W-1:0]     bin_plus_two,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output sbgf_pkg::item_ctl_type                out_ctl,
   output logic signed [sbgf_pkg::VAL_W-1:0]     out_value
);
   import sbgf_pkg::*;

   logic signed [PAIR_W-1:0] pair_one;
   logic signed [PAIR_W-1:0] pair_two;
   logic signed [PROD_W-1:0] prod_one;
   logic signed [PROD_W-1:0] prod_two;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;
   item_ctl_type             acc_ctl_ff;
   logic                     acc_valid_ff;
   logic                     acc_valid_in;
   logic                     acc_ready;

   logic signed [QUOT_W-1:0] quot;
   logic signed [VAL_W-1:0]  val_in;
   logic signed [VAL_W-1:0]  val_ff;
   item_ctl_type             val_ctl_ff;
   logic                     val_valid_ff;
   logic                     val_valid_in;

   assign acc_ready = !val_valid_ff || out_ready;
   assign in_ready  = !acc_valid_ff || acc_ready;

   always_comb begin
      pair_one = PAIR_W'(bin_minus_one) + PAIR_W'(bin_plus_one);
      pair_two = PAIR_W'(bin_minus_two) + PAIR_W'(bin_plus_two);
      prod_one = PROD_W'(pair_one) * PROD_W'(W_ONE);
      prod_two = PROD_W'(pair_two) * PROD_W'(W_TWO);
      acc_in   = (ACC_W'(bin_center) <<< CENTER_SHIFT) + ACC_W'(prod_one) + ACC_W'(prod_two);
   end

   // truncate toward zero: floor, then step up for a negative value with a fraction
   always_comb begin
      quot = QUOT_W'(acc_ff >>> FRAC_W);
      if (acc_ff[ACC_W-1] && (acc_ff[FRAC_W-1:0] != '0)) begin
         quot = quot + QUOT_W'(1);
      end
      val_in = VAL_W'(quot) + (VAL_W'(quot) <<< 1);
   end

   always_comb begin
      acc_valid_in = acc_valid_ff;
      if (in_valid && in_ready) begin
         acc_valid_in = 1'b1;
      end else if (acc_ready) begin
         acc_valid_in = 1'b0;
      end
      val_valid_in = val_valid_ff;
      if (acc_valid_ff && acc_ready) begin
         val_valid_in = 1'b1;
      end else if (out_ready) begin
         val_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         val_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= acc_valid_in;
         val_valid_ff <= val_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         acc_ff     <= acc_in;
         acc_ctl_ff <= in_ctl;
      end
      if (acc_valid_ff && acc_ready) begin
         val_ff     <= val_in;
         val_ctl_ff <= acc_ctl_ff;
      end
   end

   assign out_valid = val_valid_ff;
   assign out_ctl   = val_ctl_ff;
   assign out_value = val_ff;

endmodule

// ===== sv/sbgf_update.sv =====
// Per-bar height and fall speed store with read-modify-write and result register.
`timescale 1ns / 1ps
`include "spectrum_bar_gravity_falloff_assert.svh"
module sbgf_update (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  sbgf_pkg::item_ctl_type                in_ctl,
   input  logic signed [sbgf_pkg::VAL_W-1:0]     in_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sbgf_pkg::HEIGHT_W-1:0]         rsp_bar_height,
   output logic [sbgf_pkg::IDX_W-1:0]            rsp_display_slot,
   output logic                                  rsp_bar_settled,
   output logic                                  rsp_all_settled
);
   import sbgf_pkg::*;

   // display slot of the bar that closes a pass
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'((LAST_BAR + HALF_BARS) % BAR_COUNT);

   logic [HEIGHT_W-1:0] heights_ff [BAR_COUNT];
   logic [SPEED_W-1:0]  speeds_ff  [BAR_COUNT];
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [HEIGHT_W-1:0] rsp_bar_height_ff;
   logic [IDX_W-1:0]    rsp_display_slot_ff;
   logic                rsp_bar_settled_ff;
   logic                rsp_all_settled_ff;

   logic                take;
   logic                in_range;
   logic [SLOT_W-1:0]   bar_slot;
   logic [HEIGHT_W-1:0] h_cur;
   logic [SPEED_W-1:0]  s_cur;
   logic [SPEED_W-1:0]  s_bump;
   logic                rises;
   logic                falls_out;
   logic [HEIGHT_W-1:0] h_new;
   logic [SPEED_W-1:0]  s_new;
   logic                settled;
   logic                all_set;
   logic [IDX_W:0]      slot_sum;
   logic [IDX_W-1:0]    slot;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;
   assign in_range = ({1'b0, in_ctl.bar_index} < (IDX_W + 1)'(BAR_COUNT));
   assign bar_slot = SLOT_W'(in_ctl.bar_index);

   assign h_cur     = heights_ff[bar_slot];
   assign s_cur     = speeds_ff[bar_slot];
   assign s_bump    = (s_cur == '1) ? s_cur : s_cur + SPEED_W'(1);
   assign rises     = (in_value >= $signed({2'b00, h_cur}));
   assign falls_out = (HEIGHT_W'(s_bump) >= h_cur);

   always_comb begin
      h_new = h_cur;
      s_new = s_cur;
      if (in_ctl.action == ACT_FRAME) begin
         if (rises) begin
            h_new = in_value[HEIGHT_W-1:0];
            s_new = '0;
         end else begin
            // a frame that falls to zero keeps its bumped speed instead of clearing it
            s_new = s_bump;
            h_new = falls_out ? '0 : h_cur - HEIGHT_W'(s_bump);
         end
      end else if (h_cur != '0) begin
         if (falls_out) begin
            h_new = '0;
            s_new = '0;
         end else begin
            h_new = h_cur - HEIGHT_W'(s_bump);
            s_new = s_bump;
         end
      end
   end

   always_comb begin
      settled  = (in_ctl.action == ACT_TICK) && (h_new == '0);
      all_set  = 1'b0;
      count_in = count_ff;
      if (in_ctl.action == ACT_FRAME) begin
         count_in = '0;
      end else if (in_ctl.bar_index == IDX_W'(LAST_BAR)) begin
         all_set  = ((CNT_W + 1)'(count_ff) + (CNT_W + 1)'(settled)) == (CNT_W + 1)'(BAR_COUNT);
         count_in = '0;
      end else if (settled && (count_ff != '1)) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // mirrored slot; the sum stays below twice the bar count
   always_comb begin
      slot_sum = (IDX_W + 1)'(in_ctl.bar_index) + (IDX_W + 1)'(HALF_BARS);
      if (slot_sum >= (IDX_W + 1)'(BAR_COUNT)) begin
         slot_sum = slot_sum - (IDX_W + 1)'(BAR_COUNT);
      end
      slot = IDX_W'(slot_sum);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take && in_range) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heights_ff   <= '{default: '0};
         speeds_ff    <= '{default: '0};
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take && in_range) begin
            heights_ff[bar_slot] <= h_new;
            speeds_ff[bar_slot]  <= s_new;
            count_ff             <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_range) begin
         rsp_bar_height_ff   <= h_new;
         rsp_display_slot_ff <= slot;
         rsp_bar_settled_ff  <= settled;
         rsp_all_settled_ff  <= all_set;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bar_height   = rsp_bar_height_ff;
   assign rsp_display_slot = rsp_display_slot_ff;
   assign rsp_bar_settled  = rsp_bar_settled_ff;
   assign rsp_all_settled  = rsp_all_settled_ff;

   `SBGF_NEVER(settled_has_height, clock, reset, rsp_valid_ff && rsp_bar_settled_ff && (rsp_bar_height_ff != '0), "settled bar with nonzero height")
   `SBGF_NEVER(all_off_last_bar, clock, reset, rsp_valid_ff && rsp_all_settled_ff && (rsp_display_slot_ff != LAST_SLOT), "all settled away from the last bar")
   `SBGF_ASSERT(frame_clears_count, clock, reset, take && in_range && (in_ctl.action == ACT_FRAME) |=> (count_ff == '0), "frame did not clear settled count")
   `SBGF_ASSERT(store_matches_word, clock, reset, take && in_range |=> (heights_ff[$past(bar_slot)] == rsp_bar_height_ff), "stored height differs from result word")

endmodule

// ===== sv/spectrum_bar_gravity_falloff.sv =====
// Top level of the peak-hold spectrum bar meter with gravity falloff.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | action, bar index, five bins
//   rsp     | out       | rsp_valid/rsp_ready  | height, display slot, settled flags
//
// One word per clock sustained while the result side is ready; a taken request passes
// through the input register, accumulator stage, value stage and result register.
// The bar store is read and written in the single result stage, so back-to-back
// words to one bar see each other's update. Synchronous reset clears all bar
// heights, speeds and the settled count at once. Each stage holds while the next is
// full and stalled; empty stages fill behind a stalled result.
`timescale 1ns / 1ps
module spectrum_bar_gravity_falloff (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic [sbgf_pkg::IDX_W-1:0]            req_bar_index,
   input  logic signed [sbgf_pkg::BIN_W-1:0]     req_bin_center,
   input  logic signed [sbgf_pkg::BIN_W-1:0]     req_bin_minus_one,
   input  logic signed [sbgf_pkg::BIN_W-1:0]     req_bin_plus_one,
   input  logic signed [sbgf_pkg::BIN_W-1:0]     req_bin_minus_two,
   input  logic signed [sbgf_pkg::BIN_W-1:0]     req_bin_plus_two,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sbgf_pkg::HEIGHT_W-1:0]         rsp_bar_height,
   output logic [sbgf_pkg::IDX_W-1:0]            rsp_display_slot,
   output logic                                  rsp_bar_settled,
   output logic                                  rsp_all_settled
);
   import sbgf_pkg::*;

   logic                    in_valid_ff;
   logic                    in_valid_in;
   item_ctl_type            in_ctl_ff;
   logic signed [BIN_W-1:0] center_ff;
   logic signed [BIN_W-1:0] minus_one_ff;
   logic signed [BIN_W-1:0] plus_one_ff;
   logic signed [BIN_W-1:0] minus_two_ff;
   logic signed [BIN_W-1:0] plus_two_ff;

   logic                    weigh_ready;
   logic                    val_valid;
   logic                    upd_ready;
   item_ctl_type            val_ctl;
   logic signed [VAL_W-1:0] val_value;

   assign req_ready = !in_valid_ff || weigh_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (weigh_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ctl_ff.action    <= req_action;
         in_ctl_ff.bar_index <= req_bar_index;
         center_ff           <= req_bin_center;
         minus_one_ff        <= req_bin_minus_one;
         plus_one_ff         <= req_bin_plus_one;
         minus_two_ff        <= req_bin_minus_two;
         plus_two_ff         <= req_bin_plus_two;
      end
   end

   sbgf_weigh u_weigh (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (in_valid_ff),
      .in_ready      (weigh_ready),
      .in_ctl        (in_ctl_ff),
      .bin_center    (center_ff),
      .bin_minus_one (minus_one_ff),
      .bin_plus_one  (plus_one_ff),
      .bin_minus_two (minus_two_ff),
      .bin_plus_two  (plus_two_ff),
      .out_valid     (val_valid),
      .out_ready     (upd_ready),
      .out_ctl       (val_ctl),
      .out_value     (val_value)
   );

   sbgf_update u_update (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (val_valid),
      .in_ready         (upd_ready),
      .in_ctl           (val_ctl),
      .in_value         (val_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bar_height   (rsp_bar_height),
      .rsp_display_slot (rsp_display_slot),
      .rsp_bar_settled  (rsp_bar_settled),
      .rsp_all_settled  (rsp_all_settled)
   );

endmodule
